[src/ordered_membership_set_macros.svh]
// Assertion helpers for the ordered membership set.
// They expect clk_i and rst_ni in the scope of use.
`ifndef ORDERED_MEMBERSHIP_SET_MACROS_SVH
`define ORDERED_MEMBERSHIP_SET_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define OMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define OMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/oms_pkg.sv]
// ----------------------------------------------------------------------------
// oms_pkg
// Types and constants shared by the ordered membership set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oms_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_DEL   = 2'd1,
    FN_QUERY = 2'd2,
    FN_LIST  = 2'd3
  } oms_func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_APPLY,
    ST_SH_RD,
    ST_SH_WR,
    ST_REPLY,
    ST_LS_RD,
    ST_LS_OUT
  } oms_state_e;

endpackage

`default_nettype wire

[src/oms_store.sv]
// ----------------------------------------------------------------------------
// oms_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oms_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/ordered_membership_set.sv]
// ----------------------------------------------------------------------------
// ordered_membership_set
// Set of distinct values kept in insertion order: add, delete, query, list.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_axis carry an operation and a value. Add appends an
//   absent value, delete removes a present one and closes the gap, query
//   reports membership; each gives one output word with the count after the
//   operation. List gives one output word per element, oldest first, with
//   tlast on the final one; an empty set gives one word with tuser low.
//   One item is worked on at a time; s_axis_tready_o is high only while
//   the sequencer is idle. All entries go through one memory read port and
//   one comparator. Query, add and delete scan the entries from the oldest,
//   one read and one compare per entry, and stop at a match; delete then
//   moves each later entry down one place. List reads each entry in turn
//   and loads it as an output word. The next word can be accepted in the
//   cycle after the result is loaded. A result sits in an output register;
//   the sequencer holds while that register is occupied and m_axis_tready_i
//   is low, so a stalled receiver stalls the next result, never drops it.
//   Reset empties the set at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_membership_set_macros.svh"

module ordered_membership_set
  import oms_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // s_axis tdata: [1:0] func, [33:2] value, [39:34] zero
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // m_axis tdata: [0] was_member, [1] changed, [2] full_reject,
  //               [7:3] count, [39:8] element
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // m_axis tuser: [0] element_valid
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  localparam int unsigned SW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  oms_state_e      state_q, state_d;
  oms_func_e       op_q, op_d;
  logic [SW-1:0]   val_q, val_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   count_q, count_d;
  logic            found_q, found_d;
  logic            full_q, full_d;

  logic            out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic            out_user_q, out_user_d;
  logic            out_last_q, out_last_d;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [SW-1:0]   mem_wdata, rd_data;

  logic            accept, out_free, out_load, hit;
  logic            count_step_ok;
  logic [CW-1:0]   idx_plus;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic [SW+ELEM_W-1:0]  elem_ext;

  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~out_valid_q | m_axis_tready_i;
  assign idx_plus = idx_q + CW'(1);
  assign hit      = (rd_data == val_q);
  assign cnt_ext  = {{COUNT_W{1'b0}}, count_q};
  assign elem_ext = {{ELEM_W{1'b0}}, rd_data};

  oms_store #(
    .DEPTH (DEPTH),
    .WIDTH (SW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = (oms_func_e'(s_axis_tdata_i[FUNC_W-1:0]) == FN_LIST) ? ST_LS_RD
                                                                          : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == count_q) begin
          state_d = (op_q == FN_ADD) ? ST_APPLY : ST_REPLY;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (hit) begin
          case (op_q)
            FN_ADD:  state_d = ST_APPLY;
            FN_DEL:  state_d = ST_SH_RD;
            default: state_d = ST_REPLY;
          endcase
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_APPLY:  state_d = ST_REPLY;
      ST_SH_RD:  state_d = (idx_plus < count_q) ? ST_SH_WR : ST_REPLY;
      ST_SH_WR:  state_d = ST_SH_RD;
      ST_REPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_LS_RD:  state_d = (count_q == '0) ? ST_REPLY : ST_LS_OUT;
      ST_LS_OUT: begin
        if (out_free) begin
          state_d = (idx_plus == count_q) ? ST_IDLE : ST_LS_RD;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_raddr   = idx_q[AW-1:0];
    mem_wdata   = rd_data;
    out_load    = 1'b0;
    op_d        = op_q;
    val_d       = val_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    full_d      = full_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_d    = oms_func_e'(s_axis_tdata_i[FUNC_W-1:0]);
          val_d   = s_axis_tdata_i[FUNC_W +: SW];
          idx_d   = '0;
          found_d = 1'b0;
          full_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        mem_re = (idx_q != count_q);
      end
      ST_CMP: begin
        if (hit) begin
          found_d = 1'b1;
        end else begin
          idx_d = idx_plus;
        end
      end
      ST_APPLY: begin
        if (!found_q) begin
          if (count_q == CW'(DEPTH)) begin
            full_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_q[AW-1:0];
            mem_wdata = val_q;
            count_d   = count_q + CW'(1);
          end
        end
      end
      ST_SH_RD: begin
        // move the next entry down one place, or finish the delete
        if (idx_plus < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_plus[AW-1:0];
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      ST_SH_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_plus;
      end
      ST_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = '0;
          out_data_d[0]   = (op_q != FN_LIST) & found_q;
          out_data_d[1]   = ((op_q == FN_ADD) & ~found_q & ~full_q)
                          | ((op_q == FN_DEL) & found_q);
          out_data_d[2]   = full_q;
          out_data_d[7:3] = cnt_ext[COUNT_W-1:0];
          out_user_d = 1'b0;
          out_last_d = 1'b1;
        end
      end
      ST_LS_RD: begin
        mem_re = (count_q != '0);
      end
      ST_LS_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = '0;
          out_data_d[7:3]  = cnt_ext[COUNT_W-1:0];
          out_data_d[39:8] = elem_ext[ELEM_W-1:0];
          out_user_d = 1'b1;
          out_last_d = (idx_plus == count_q);
          idx_d      = idx_plus;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      op_q        <= FN_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      full_q      <= full_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // count holds or moves by one per cycle
  assign count_step_ok = (count_d == count_q) | (count_d == count_q + CW'(1))
                       | (count_d == count_q - CW'(1));

  `OMS_ASSERT_NEVER(a_count_bound, count_q > CW'(DEPTH), "count exceeds store depth")
  `OMS_ASSERT(a_count_step, count_step_ok, "count moved by more than one")
  `OMS_ASSERT(a_busy_after_accept, accept |=> (state_q != ST_IDLE), "idle right after accept")
  `OMS_ASSERT_NEVER(a_out_overwrite, out_load && !out_free, "held result overwritten")

endmodule

`default_nettype wire
